[hw/rtl/swtq_pkg.sv]
// ---------------------------------------------------------------------------
// Sorted wake-up timer queue package
// Shared constants, result codes and the wrap-aware time compare.
// ---------------------------------------------------------------------------
package swtq_pkg;

  // Default sizing of the queue.
  localparam int QueueDepthDefault = 16;
  localparam int IdBitsDefault     = 8;

  // Upper bound on releases caused by a single tick.
  localparam int MaxResults = 16;

  // Field widths fixed by the interface.
  localparam int TimeW  = 64;
  localparam int DurW   = 32;
  localparam int PortIdW = 8;
  localparam int TickOutW = 63;

  // Action codes of an input word.
  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_SLEEP = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_ACCEPTED = 2'd0;
  localparam logic [1:0] KIND_REJECTED = 2'd1;
  localparam logic [1:0] KIND_RELEASED = 2'd2;

  // Wake times and the counter wrap, so they compare as signed values.
  function automatic logic time_le(input logic [TimeW-1:0] a, input logic [TimeW-1:0] b);
    return $signed(a) <= $signed(b);
  endfunction

endpackage

[hw/rtl/sorted_wakeup_timer_queue.sv]
// ---------------------------------------------------------------------------
// Sorted wake-up timer queue
// Tick-driven queue of sleepers kept in ascending wake-time order.
// ---------------------------------------------------------------------------
// A command word is taken when start_i is high and busy_o is low. A sleep
// word (action_i = 1) stores sleeper_id_i with wake time = counter plus the
// sign-extended sleep_ticks_i, placed after every entry due at or before it.
// It answers one word: accepted, or rejected when the queue is full. A tick
// word (action_i = 0) bumps the 64-bit counter and then releases every entry
// due at or before the new count, head first, up to 16 per tick; last_o
// marks the final word. A tick that releases nothing gives no word.
// Each result word shows on the output ports for one cycle under strobe_o;
// the receiver cannot stall it. current_tick_o is the counter's low 63 bits.
// Entries live in a ring buffer read through one registered port, and one
// shared compare unit walks the queue. A sleep on a full queue never raises
// busy_o. An accepted sleep holds busy_o while it moves later entries toward
// the tail, and a tick holds it while it releases entries. The final word of
// a command shows in the first cycle with busy_o low.
// Reset empties the queue and clears the counter; no clearing pass is run.
// ---------------------------------------------------------------------------
module sorted_wakeup_timer_queue
  import swtq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepthDefault,
  parameter int ID_BITS     = IdBitsDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic                       action_i,
  input  logic [PortIdW-1:0]         sleeper_id_i,
  input  logic signed [DurW-1:0]     sleep_ticks_i,
  output logic                       strobe_o,
  output logic [1:0]                 kind_o,
  output logic [PortIdW-1:0]         released_id_o,
  output logic [TickOutW-1:0]        current_tick_o,
  output logic                       last_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int REL_W = $clog2(MaxResults + 1);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SRD  = 3'd1;
  localparam logic [2:0] ST_SCMP = 3'd2;
  localparam logic [2:0] ST_TRD  = 3'd3;
  localparam logic [2:0] ST_TCMP = 3'd4;

  // Physical slot of a logical offset from the head, wrapped into the ring.
  function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] base,
                                             input logic [CNT_W-1:0] off);
    logic [PTR_W:0] sum;
    sum = {1'b0, base} + {1'b0, off[PTR_W-1:0]};
    if (sum >= (PTR_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (PTR_W+1)'(QUEUE_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  logic [2:0]         state_q, state_d;
  logic [PTR_W-1:0]   head_q, head_d;
  logic [CNT_W-1:0]   occ_q, occ_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic [REL_W-1:0]   rel_q, rel_d;
  logic [TimeW-1:0]   tick_q, tick_d;
  logic [TimeW-1:0]   wake_q, wake_d;
  logic [ID_BITS-1:0] new_id_q, new_id_d;
  logic               pend_vld_q, pend_vld_d;
  logic [ID_BITS-1:0] pend_id_q, pend_id_d;
  logic               strobe_q, strobe_d;
  logic [1:0]         kind_q, kind_d;
  logic [PortIdW-1:0] rid_q, rid_d;
  logic               last_q, last_d;

  // Entry storage and its single read port.
  logic [TimeW-1:0]   wake_mem [QUEUE_DEPTH];
  logic [ID_BITS-1:0] id_mem   [QUEUE_DEPTH];
  logic               mem_we, mem_re;
  logic [PTR_W-1:0]   mem_waddr, mem_raddr;
  logic [TimeW-1:0]   mem_wwake;
  logic [ID_BITS-1:0] mem_wid;
  logic [TimeW-1:0]   rd_wake_q;
  logic [ID_BITS-1:0] rd_id_q;

  logic [ID_BITS-1:0] id_in;
  logic [CNT_W-1:0]   idx_m1;
  logic [TimeW-1:0]   cmp_ref;
  logic               cmp_le;

  assign id_in  = ID_BITS'(sleeper_id_i);
  assign idx_m1 = idx_q - CNT_W'(1);

  // Shared compare unit: the entry just read against the new wake time while
  // inserting, or against the counter while releasing.
  assign cmp_ref = (state_q == ST_SCMP) ? wake_q : tick_q;
  assign cmp_le  = time_le(rd_wake_q, cmp_ref);

  // Sequencer: sorted insert walks from the tail, release walks from the head.
  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    occ_d      = occ_q;
    idx_d      = idx_q;
    rel_d      = rel_q;
    tick_d     = tick_q;
    wake_d     = wake_q;
    new_id_d   = new_id_q;
    pend_vld_d = pend_vld_q;
    pend_id_d  = pend_id_q;
    strobe_d   = 1'b0;
    kind_d     = kind_q;
    rid_d      = rid_q;
    last_d     = last_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = phys(head_q, idx_q);
    mem_raddr  = head_q;
    mem_wwake  = wake_q;
    mem_wid    = new_id_q;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (action_i == ACT_SLEEP) begin
            new_id_d = id_in;
            if (occ_q >= CNT_W'(QUEUE_DEPTH)) begin
              strobe_d = 1'b1;
              kind_d   = KIND_REJECTED;
              rid_d    = PortIdW'(id_in);
              last_d   = 1'b1;
            end else begin
              wake_d  = tick_q + {{(TimeW-DurW){sleep_ticks_i[DurW-1]}}, sleep_ticks_i};
              idx_d   = occ_q;
              state_d = ST_SRD;
            end
          end else begin
            tick_d     = tick_q + TimeW'(1);
            rel_d      = '0;
            pend_vld_d = 1'b0;
            state_d    = ST_TRD;
          end
        end
      end

      ST_SRD: begin
        if (idx_q == '0) begin
          // Reached the head: the new entry goes first.
          mem_we   = 1'b1;
          occ_d    = occ_q + CNT_W'(1);
          strobe_d = 1'b1;
          kind_d   = KIND_ACCEPTED;
          rid_d    = PortIdW'(new_id_q);
          last_d   = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = phys(head_q, idx_m1);
          state_d   = ST_SCMP;
        end
      end

      ST_SCMP: begin
        mem_we = 1'b1;
        if (cmp_le) begin
          // Neighbor is due no later: insert behind it.
          occ_d    = occ_q + CNT_W'(1);
          strobe_d = 1'b1;
          kind_d   = KIND_ACCEPTED;
          rid_d    = PortIdW'(new_id_q);
          last_d   = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          // Move the neighbor one slot toward the tail.
          mem_wwake = rd_wake_q;
          mem_wid   = rd_id_q;
          idx_d     = idx_m1;
          state_d   = ST_SRD;
        end
      end

      ST_TRD: begin
        if (occ_q != '0 && rel_q < REL_W'(MaxResults)) begin
          mem_re    = 1'b1;
          mem_raddr = head_q;
          state_d   = ST_TCMP;
        end else begin
          if (pend_vld_q) begin
            strobe_d = 1'b1;
            kind_d   = KIND_RELEASED;
            rid_d    = PortIdW'(pend_id_q);
            last_d   = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end

      ST_TCMP: begin
        // The held release goes out once we know whether another follows.
        if (pend_vld_q) begin
          strobe_d = 1'b1;
          kind_d   = KIND_RELEASED;
          rid_d    = PortIdW'(pend_id_q);
          last_d   = !cmp_le;
        end
        if (cmp_le) begin
          pend_vld_d = 1'b1;
          pend_id_d  = rd_id_q;
          head_d     = phys(head_q, CNT_W'(1));
          occ_d      = occ_q - CNT_W'(1);
          rel_d      = rel_q + REL_W'(1);
          state_d    = ST_TRD;
        end else begin
          pend_vld_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      head_q     <= '0;
      occ_q      <= '0;
      rel_q      <= '0;
      tick_q     <= '0;
      pend_vld_q <= 1'b0;
      strobe_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      occ_q      <= occ_d;
      rel_q      <= rel_d;
      tick_q     <= tick_d;
      pend_vld_q <= pend_vld_d;
      strobe_q   <= strobe_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    wake_q    <= wake_d;
    new_id_q  <= new_id_d;
    pend_id_q <= pend_id_d;
    kind_q    <= kind_d;
    rid_q     <= rid_d;
    last_q    <= last_d;
  end

  // Entry memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      wake_mem[mem_waddr] <= mem_wwake;
      id_mem[mem_waddr]   <= mem_wid;
    end
    if (mem_re) begin
      rd_wake_q <= wake_mem[mem_raddr];
      rd_id_q   <= id_mem[mem_raddr];
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign strobe_o       = strobe_q;
  assign kind_o         = kind_q;
  assign released_id_o  = rid_q;
  assign current_tick_o = tick_q[TickOutW-1:0];
  assign last_o         = last_q;

endmodule
